// File: sv/ptsa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptsa_pkg
// Shared constants, opcodes and the stage-control struct for the tone and
// saturation pipeline.
// ---------------------------------------------------------------------------
package ptsa_pkg;

    localparam logic OP_CURVE_WRITE = 1'b0;
    localparam logic OP_PIXEL       = 1'b1;

    localparam logic REG_SAT_GAIN = 1'b0;
    localparam logic REG_VIB_GAIN = 1'b1;

    localparam int CFG_W = 14;

    localparam logic signed [17:0] K_YR = 18'sd9798;
    localparam logic signed [17:0] K_YG = 18'sd19235;
    localparam logic signed [17:0] K_YB = 18'sd3736;
    localparam logic signed [17:0] K_UR = -18'sd4817;
    localparam logic signed [17:0] K_UG = -18'sd9470;
    localparam logic signed [17:0] K_UB = 18'sd14287;
    localparam logic signed [17:0] K_VR = 18'sd20152;
    localparam logic signed [17:0] K_VG = -18'sd16876;
    localparam logic signed [17:0] K_VB = -18'sd3277;
    localparam logic signed [17:0] K_CU0 = -18'sd3441;
    localparam logic signed [17:0] K_CV0 = 18'sd7438;
    localparam logic signed [17:0] K_RV = 18'sd37356;
    localparam logic signed [17:0] K_GU = 18'sd12976;
    localparam logic signed [17:0] K_GV = 18'sd19038;
    localparam logic signed [17:0] K_BU = 18'sd66486;

    // Number of restoring square-root stages (result bits).
    localparam int SQRT_BITS = 17;

    typedef struct packed {
        logic valid;
        logic [7:0] alpha;
    } t_ctl;

    // Symmetric rounding shift, halves away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic [63:0] half;
        logic [63:0] mag;
        half = 64'd1 << (s - 1);
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + half) >> s;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [7:0] to_byte(input logic signed [19:0] q);
        logic signed [29:0] b;
        b = (30'(q) * 30'sd255 + 30'sd16384) >>> 15;
        if (q <= 0) return 8'd0;
        if (b > 30'sd255) return 8'd255;
        return b[7:0];
    endfunction

endpackage

// File: sv/ptsa_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptsa_sqrt
// Pipelined restoring integer square root, one result bit per stage, with a
// side payload that travels alongside and a common enable.
// ---------------------------------------------------------------------------
module ptsa_sqrt import ptsa_pkg::*; #(
    parameter int PAY_W = 64
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [33:0]          i_rad,
    input  logic [PAY_W-1:0]     i_pay,
    output logic [SQRT_BITS-1:0] o_root,
    output logic [PAY_W-1:0]     o_pay
);

    logic [33:0]          r_rem  [SQRT_BITS];
    logic [SQRT_BITS-1:0] r_root [SQRT_BITS];
    logic [PAY_W-1:0]     r_pay  [SQRT_BITS];

    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_stage
        localparam int B = SQRT_BITS - 1 - k;
        logic [33:0]          n_rem;
        logic [SQRT_BITS-1:0] n_root;
        logic [PAY_W-1:0]     n_pay;
        logic [35:0] n_trial;
        logic [35:0] n_sh;
        if (k == 0) begin : g_first
            assign n_rem  = i_rad;
            assign n_root = '0;
            assign n_pay  = i_pay;
        end else begin : g_next
            assign n_rem  = r_rem[k-1];
            assign n_root = r_root[k-1];
            assign n_pay  = r_pay[k-1];
        end
        always_comb begin
            n_sh    = {2'b00, n_rem} >> (2 * B);
            n_trial = 36'({n_root, 2'b01});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pay[k] <= n_pay;
                if (n_sh >= n_trial) begin
                    r_rem[k]  <= n_rem - 34'(n_trial << (2 * B));
                    r_root[k] <= (n_root << 1) | 1'b1;
                end else begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root << 1;
                end
            end
        end
    end

    assign o_root = r_root[SQRT_BITS-1];
    assign o_pay  = r_pay[SQRT_BITS-1];

endmodule

// File: sv/pixel_tone_saturation_adjust_core.sv
`timescale 1ns / 1ps
// Pipeline: the stages below run from pixel accept to result valid, 17 of them root stages.
// Throughput: one word per cycle; the whole pipe advances when the output
// register is empty or being taken.
// Reset: synchronous active low, clears valid bits and config to 4096 / 0;
// the tone curve is undefined until written.
// ---------------------------------------------------------------------------
// pixel_tone_saturation_adjust_core
// YUV tone curve and saturation/vibrance adjustment, streaming pipeline.
// ---------------------------------------------------------------------------
module pixel_tone_saturation_adjust_core import ptsa_pkg::*; #(
    parameter int CURVE_ENTRIES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_operation,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic [7:0]       i_alpha,
    input  logic [7:0]       i_curve_index,
    input  logic [15:0]      i_curve_value,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic [7:0]       o_alpha_out
);

    localparam int AW = $clog2(CURVE_ENTRIES);

    logic        en;
    logic [13:0] r_sat;
    logic signed [13:0] r_vib;
    logic [15:0] r_curve [CURVE_ENTRIES];

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 14'd4096;
            r_vib <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SAT_GAIN: r_sat <= i_cfg_data;
                REG_VIB_GAIN: r_vib <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // stage 1: expand channels, capture curve write
    t_ctl r_c1;
    logic signed [17:0] r1_r, r1_g, r1_b;
    logic          r1_we;
    logic [AW-1:0] r1_wa;
    logic [15:0]   r1_wd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid <= 1'b0;
            r1_we      <= 1'b0;
        end else if (en) begin
            r_c1.valid <= i_valid && (i_operation == OP_PIXEL);
            r1_we      <= i_valid && (i_operation == OP_CURVE_WRITE)
                          && (32'(i_curve_index) < CURVE_ENTRIES);
        end
        if (en) begin
            r_c1.alpha <= i_alpha;
            r1_r <= 18'((17'(i_red) * 17'd257) >> 1);
            r1_g <= 18'((17'(i_green) * 17'd257) >> 1);
            r1_b <= 18'((17'(i_blue) * 17'd257) >> 1);
            r1_wa <= AW'(i_curve_index);
            r1_wd <= i_curve_value;
        end
    end

    // stage 2: matrix products
    t_ctl r_c2;
    logic signed [36:0] r2_y, r2_u, r2_v;
    logic          r2_we;
    logic [AW-1:0] r2_wa;
    logic [15:0]   r2_wd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2.valid <= 1'b0;
            r2_we      <= 1'b0;
        end else if (en) begin
            r_c2.valid <= r_c1.valid;
            r2_we      <= r1_we;
        end
        if (en) begin
            r_c2.alpha <= r_c1.alpha;
            r2_y <= 37'(K_YR) * 37'(r1_r) + 37'(K_YG) * 37'(r1_g) + 37'(K_YB) * 37'(r1_b);
            r2_u <= 37'(K_UR) * 37'(r1_r) + 37'(K_UG) * 37'(r1_g) + 37'(K_UB) * 37'(r1_b);
            r2_v <= 37'(K_VR) * 37'(r1_r) + 37'(K_VG) * 37'(r1_g) + 37'(K_VB) * 37'(r1_b);
            r2_wa <= r1_wa;
            r2_wd <= r1_wd;
        end
    end

    // stage 3: round, curve index, chroma distance
    t_ctl r_c3;
    logic signed [17:0] r3_u, r3_v, r3_dx, r3_dy;
    logic [AW-1:0] r3_idx;
    logic          r3_we;
    logic [AW-1:0] r3_wa;
    logic [15:0]   r3_wd;
    logic signed [63:0] n3_y, n3_u, n3_v;
    logic [63:0] n3_ix;
    always_comb begin
        n3_y = rnd_shift(64'(r2_y), 15);
        n3_u = rnd_shift(64'(r2_u), 15);
        n3_v = rnd_shift(64'(r2_v), 15);
        if (n3_y < 0) n3_y = '0;
        n3_ix = (64'(n3_y) * 64'(CURVE_ENTRIES)) >> 15;
        if (n3_ix > 64'(CURVE_ENTRIES - 1)) n3_ix = 64'(CURVE_ENTRIES - 1);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3.valid <= 1'b0;
            r3_we      <= 1'b0;
        end else if (en) begin
            r_c3.valid <= r_c2.valid;
            r3_we      <= r2_we;
        end
        if (en) begin
            r_c3.alpha <= r_c2.alpha;
            r3_u   <= 18'(n3_u);
            r3_v   <= 18'(n3_v);
            r3_dx  <= 18'(64'(K_CU0) - n3_u);
            r3_dy  <= 18'(64'(K_CV0) - n3_v);
            r3_idx <= n3_ix[AW-1:0];
            r3_wa  <= r2_wa;
            r3_wd  <= r2_wd;
        end
    end

    // stage 4: curve write or read, squares
    t_ctl r_c4;
    logic signed [17:0] r4_u, r4_v;
    logic [15:0] r4_lut;
    logic [33:0] r4_dsq;
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r3_we) r_curve[r3_wa] <= r3_wd;
            r4_lut <= r_curve[r3_idx];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c4.valid <= 1'b0;
        else if (en) r_c4.valid <= r_c3.valid;
        if (en) begin
            r_c4.alpha <= r_c3.alpha;
            r4_u   <= r3_u;
            r4_v   <= r3_v;
            r4_dsq <= 34'(36'(r3_dx) * 36'(r3_dx) + 36'(r3_dy) * 36'(r3_dy));
        end
    end

    // stages 5..21: square root
    localparam int PW = 8 + 18 + 18 + 16;
    logic [PW-1:0] sq_pay;
    logic [SQRT_BITS-1:0] sq_root;
    t_ctl c5;
    logic signed [17:0] s_u, s_v;
    logic [15:0] s_lut;
    logic [PW-1:0] sq_in;
    assign sq_in = {r_c4.alpha, r4_u, r4_v, r4_lut};

    ptsa_sqrt #(.PAY_W(PW)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r4_dsq),
        .i_pay  (sq_in),
        .o_root (sq_root),
        .o_pay  (sq_pay)
    );

    logic [SQRT_BITS-1:0] r_vpipe;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vpipe <= '0;
        else if (en) r_vpipe <= {r_vpipe[SQRT_BITS-2:0], r_c4.valid};
    end
    assign c5.valid = r_vpipe[SQRT_BITS-1];
    assign {c5.alpha, s_u, s_v, s_lut} = sq_pay;

    // stage 22: boost factor
    t_ctl r_c6;
    logic signed [17:0] r6_u, r6_v;
    logic [15:0] r6_lut;
    logic signed [17:0] r6_fac;
    logic signed [63:0] n6_f;
    always_comb n6_f = 64'sd4096
        + rnd_shift(64'(32'(r_vib) * 32'($signed({1'b0, sq_root}))), 13);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c6.valid <= 1'b0;
        else if (en) r_c6.valid <= c5.valid;
        if (en) begin
            r_c6.alpha <= c5.alpha;
            r6_u <= s_u; r6_v <= s_v; r6_lut <= s_lut;
            r6_fac <= 18'(n6_f);
        end
    end

    // stage 23: effective gain
    t_ctl r_c7;
    logic signed [17:0] r7_u, r7_v;
    logic [15:0] r7_lut;
    logic signed [19:0] r7_sat;
    logic signed [63:0] n7_s;
    always_comb begin
        n7_s = 64'($signed({1'b0, r_sat}));
        if (r_vib != 0)
            n7_s = rnd_shift(64'(32'($signed({1'b0, r_sat})) * 32'(r6_fac)), 12);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c7.valid <= 1'b0;
        else if (en) r_c7.valid <= r_c6.valid;
        if (en) begin
            r_c7.alpha <= r_c6.alpha;
            r7_u <= r6_u; r7_v <= r6_v; r7_lut <= r6_lut;
            r7_sat <= 20'(n7_s);
        end
    end

    // stage 24: chroma scale and clamp
    t_ctl r_c8;
    logic signed [17:0] r8_u, r8_v;
    logic [15:0] r8_y;
    logic signed [63:0] n8_u, n8_v;
    always_comb begin
        n8_u = rnd_shift(64'(38'(r7_u) * 38'(r7_sat)), 12);
        n8_v = rnd_shift(64'(38'(r7_v) * 38'(r7_sat)), 12);
        if (n8_u > 64'sd32768) n8_u = 64'sd32768;
        if (n8_u < -64'sd32768) n8_u = -64'sd32768;
        if (n8_v > 64'sd32768) n8_v = 64'sd32768;
        if (n8_v < -64'sd32768) n8_v = -64'sd32768;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c8.valid <= 1'b0;
        else if (en) r_c8.valid <= r_c7.valid;
        if (en) begin
            r_c8.alpha <= r_c7.alpha;
            r8_u <= 18'(n8_u);
            r8_v <= 18'(n8_v);
            r8_y <= 16'((17'(r7_lut) + 17'd1) >> 1);
        end
    end

    // stage 25: back to RGB, output register
    logic signed [63:0] n9_r, n9_g, n9_b;
    always_comb begin
        n9_r = 64'(r8_y) + rnd_shift(64'(36'(r8_v) * 36'(K_RV)), 15);
        n9_g = 64'(r8_y) - rnd_shift(64'(36'(r8_u) * 36'(K_GU)), 15)
             - rnd_shift(64'(36'(r8_v) * 36'(K_GV)), 15);
        n9_b = 64'(r8_y) + rnd_shift(64'(36'(r8_u) * 36'(K_BU)), 15);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en) o_valid <= r_c8.valid;
        if (en) begin
            o_alpha_out <= r_c8.alpha;
            o_red_out   <= to_byte(20'(n9_r));
            o_green_out <= to_byte(20'(n9_g));
            o_blue_out  <= to_byte(20'(n9_b));
        end
    end

`ifndef SYNTH
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red_out))
        else $error("output changed under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("stall mismatch");
    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_operation == OP_CURVE_WRITE |=> !r_c1.valid)
        else $error("curve write made a result");
`endif

endmodule
